@@ rtl/core/fqr_pkg.sv @@
package fqr_pkg;

  // operation codes
  localparam logic [1:0] MODE_PUT    = 2'd0;
  localparam logic [1:0] MODE_GET    = 2'd1;
  localparam logic [1:0] MODE_REMOVE = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  // value returned on a failed operation
  localparam logic signed [31:0] FAIL_VALUE = -32'sd1;

  localparam int unsigned OCC_W = 5;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] value;
  } fqr_in_t;

  typedef struct packed {
    logic signed [31:0] value_out;
    logic [1:0]         status;
    logic [OCC_W-1:0]   occupancy;
  } fqr_out_t;

  // finished result from the sequencer
  typedef struct packed {
    logic     done;
    fqr_out_t item;
  } fqr_res_t;

endpackage

@@ rtl/core/fifo_queue_with_remove_by_value_core.sv @@
// Bounded first-in first-out queue of signed 32-bit values with remove by value.
// Each item is put (append), get (take the oldest) or remove (delete every held
// entry equal to the value, keeping the order of the rest), and each item gives
// exactly one result with the value, a status and the occupancy. The entries sit
// in a single-port-write, registered-read RAM used as a circular buffer. Put, an
// unused mode and any failure on an empty or full queue finish in the accepting
// cycle; get finishes once the RAM read returns the oldest entry; remove runs one
// compare-and-compact step per stored entry through the RAM ports.
// The block takes no new item until the current one has finished and its result
// is leaving the output register; a stalled result stalls the input as well.
module fifo_queue_with_remove_by_value_core #(
  parameter int unsigned DEPTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  fqr_pkg::fqr_in_t in_item_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output fqr_pkg::fqr_out_t out_item_o
);

  import fqr_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);

  logic          busy;
  logic          start;
  fqr_res_t      res;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [31:0]   ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [31:0]   ram_rdata;
  logic          out_valid_q;
  fqr_out_t      out_item_q;

  // input handshake: idle and result slot free or draining
  assign in_stall_o = busy | (out_valid_q & out_stall_i);
  assign start      = in_valid_i & ~in_stall_o;

  fqr_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .item_i     (in_item_i),
    .busy_o     (busy),
    .res_o      (res),
    .ram_we_o   (ram_we),
    .ram_waddr_o(ram_waddr),
    .ram_wdata_o(ram_wdata),
    .ram_re_o   (ram_re),
    .ram_raddr_o(ram_raddr),
    .ram_rdata_i(ram_rdata)
  );

  fqr_ram #(
    .WIDTH(32),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.done) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.done) begin
      out_item_q <= res.item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

@@ rtl/core/fqr_ram.sv @@
module fqr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // one write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, held while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

@@ rtl/core/fqr_ctrl.sv @@
module fqr_ctrl #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  fqr_pkg::fqr_in_t         item_i,
  output logic                     busy_o,
  output fqr_pkg::fqr_res_t        res_o,
  output logic                     ram_we_o,
  output logic [$clog2(DEPTH)-1:0] ram_waddr_o,
  output logic [31:0]              ram_wdata_o,
  output logic                     ram_re_o,
  output logic [$clog2(DEPTH)-1:0] ram_raddr_o,
  input  logic [31:0]              ram_rdata_i
);

  import fqr_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_GET  = 3'b010,
    S_SCAN = 3'b100
  } state_e;

  state_e             state_q, state_d;
  logic [AW-1:0]      head_q, head_d;
  logic [AW-1:0]      tail_q, tail_d;
  logic [CW-1:0]      count_q, count_d;
  logic [AW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [AW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [CW-1:0]      idx_q, idx_d;
  logic [CW-1:0]      cmp_q, cmp_d;
  logic [CW-1:0]      kept_q, kept_d;
  logic               rv_q, rv_d;
  logic signed [31:0] key_q, key_d;

  // circular pointer step
  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == LAST) ? '0 : p + AW'(1);
  endfunction

  assign busy_o = (state_q != S_IDLE);

  // sequencer and scan datapath
  always_comb begin
    state_d  = state_q;
    head_d   = head_q;
    tail_d   = tail_q;
    count_d  = count_q;
    rd_ptr_d = rd_ptr_q;
    wr_ptr_d = wr_ptr_q;
    idx_d    = idx_q;
    cmp_d    = cmp_q;
    kept_d   = kept_q;
    rv_d     = 1'b0;
    key_d    = key_q;

    ram_we_o    = 1'b0;
    ram_waddr_o = tail_q;
    ram_wdata_o = item_i.value;
    ram_re_o    = 1'b0;
    ram_raddr_o = head_q;

    res_o.done           = 1'b0;
    res_o.item.value_out = 32'sd0;
    res_o.item.status    = ST_OK;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          case (item_i.mode)
            MODE_PUT: begin
              res_o.done = 1'b1;
              if (count_q == FULL) begin
                res_o.item.value_out = FAIL_VALUE;
                res_o.item.status    = ST_FULL;
              end else begin
                ram_we_o = 1'b1;
                tail_d   = ptr_inc(tail_q);
                count_d  = count_q + CW'(1);
              end
            end
            MODE_GET: begin
              if (count_q == '0) begin
                res_o.done           = 1'b1;
                res_o.item.value_out = FAIL_VALUE;
                res_o.item.status    = ST_EMPTY;
              end else begin
                ram_re_o = 1'b1;
                state_d  = S_GET;
              end
            end
            MODE_REMOVE: begin
              if (count_q == '0) begin
                res_o.done           = 1'b1;
                res_o.item.value_out = FAIL_VALUE;
                res_o.item.status    = ST_EMPTY;
              end else begin
                key_d    = item_i.value;
                rd_ptr_d = head_q;
                wr_ptr_d = head_q;
                idx_d    = '0;
                cmp_d    = '0;
                kept_d   = '0;
                state_d  = S_SCAN;
              end
            end
            default: begin
              res_o.done = 1'b1;
            end
          endcase
        end
      end

      // oldest entry arrives from the store
      S_GET: begin
        res_o.done           = 1'b1;
        res_o.item.value_out = ram_rdata_i;
        head_d               = ptr_inc(head_q);
        count_d              = count_q - CW'(1);
        state_d              = S_IDLE;
      end

      // read ahead one entry a cycle, compare and compact behind
      S_SCAN: begin
        if (idx_q != count_q) begin
          ram_re_o    = 1'b1;
          ram_raddr_o = rd_ptr_q;
          rd_ptr_d    = ptr_inc(rd_ptr_q);
          idx_d       = idx_q + CW'(1);
          rv_d        = 1'b1;
        end
        if (rv_q) begin
          if (ram_rdata_i != key_q) begin
            ram_we_o    = 1'b1;
            ram_waddr_o = wr_ptr_q;
            ram_wdata_o = ram_rdata_i;
            wr_ptr_d    = ptr_inc(wr_ptr_q);
            kept_d      = kept_q + CW'(1);
          end
          cmp_d = cmp_q + CW'(1);
          if (cmp_d == count_q) begin
            res_o.done = 1'b1;
            state_d    = S_IDLE;
            if (kept_d == count_q) begin
              res_o.item.value_out = FAIL_VALUE;
              res_o.item.status    = ST_NOTFOUND;
            end else begin
              res_o.item.value_out = key_q;
              count_d              = kept_d;
              tail_d               = wr_ptr_d;
            end
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    res_o.item.occupancy = OCC_W'(count_d);
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      rv_q    <= rv_d;
    end
  end

  // scan working registers
  always_ff @(posedge clk_i) begin
    rd_ptr_q <= rd_ptr_d;
    wr_ptr_q <= wr_ptr_d;
    idx_q    <= idx_d;
    cmp_q    <= cmp_d;
    kept_q   <= kept_d;
    key_q    <= key_d;
  end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import fqr_pkg::*;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned RANDOM_ITEMS = 1625;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = 2 * DEPTH + 8;
  localparam int unsigned REPORT_MAX = 10;
  // mode code the block leaves unused
  localparam logic [1:0] MODE_SPARE = 2'd3;

  typedef struct {
    fqr_in_t     op;
    int unsigned gap;
    bit          drain;
  } pending_t;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  fqr_in_t  in_item = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  fqr_out_t out_item;

  // stimulus and prediction state
  pending_t           pending_ops[$];
  fqr_out_t           awaited_results[$];
  logic signed [31:0] held_values[$];
  pending_t           nxt;
  fqr_out_t           want;
  bit                 took;
  bit                 quiet;
  bit                 calm = 1'b0;
  int unsigned        gap_left;
  int unsigned        stall_left;
  int unsigned        items_taken;
  int unsigned        results_seen;
  int unsigned        cycle_count;
  int unsigned        mismatches;
  int unsigned        mode_taken[4];
  int unsigned        status_seen[4];

  fifo_queue_with_remove_by_value_core #(
    .DEPTH(DEPTH)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item)
  );

  // clock
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // queue behaviour: apply one operation to the held values and give its result
  function automatic fqr_out_t queue_op_result(fqr_in_t op);
    fqr_out_t           r;
    logic signed [31:0] kept[$];
    r.value_out = 32'sd0;
    r.status    = ST_OK;
    case (op.mode)
      MODE_PUT: begin
        if (held_values.size() >= DEPTH) begin
          r.value_out = FAIL_VALUE;
          r.status    = ST_FULL;
        end else begin
          held_values.push_back(op.value);
        end
      end
      MODE_GET: begin
        if (held_values.size() == 0) begin
          r.value_out = FAIL_VALUE;
          r.status    = ST_EMPTY;
        end else begin
          r.value_out = held_values.pop_front();
        end
      end
      MODE_REMOVE: begin
        if (held_values.size() == 0) begin
          r.value_out = FAIL_VALUE;
          r.status    = ST_EMPTY;
        end else begin
          foreach (held_values[i]) begin
            if (held_values[i] != op.value) kept.push_back(held_values[i]);
          end
          if (kept.size() == held_values.size()) begin
            r.value_out = FAIL_VALUE;
            r.status    = ST_NOTFOUND;
          end else begin
            held_values = kept;
            r.value_out = op.value;
          end
        end
      end
      default: begin
      end
    endcase
    r.occupancy = OCC_W'(held_values.size());
    return r;
  endfunction

  // idle lengths: mostly none or short, a few long
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // values lean towards the extremes now and then
  function automatic logic signed [31:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    case (roll)
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return -32'sd1;
      3: return 32'sd0;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_item(input logic [1:0] mode, input logic signed [31:0] value,
                          input bit drain);
    pending_t p;
    p.op.mode  = mode;
    p.op.value = value;
    p.gap      = quiet ? 0 : pick_gap();
    p.drain    = drain;
    pending_ops.push_back(p);
  endtask

  // driver: presents pending items and predicts each one as it is taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid    <= 1'b0;
      in_item     <= '0;
      gap_left    <= 0;
      items_taken <= 0;
    end else begin
      took = in_valid && !in_stall;
      if (took) begin
        awaited_results.push_back(queue_op_result(in_item));
        mode_taken[in_item.mode]++;
        items_taken <= items_taken + 1;
      end
      if (!in_valid || took) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_ops.size() != 0 &&
                     !(pending_ops[0].drain && items_taken + took != results_seen)) begin
          nxt = pending_ops.pop_front();
          in_valid <= 1'b1;
          in_item  <= nxt.op;
          gap_left <= nxt.gap;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result against the oldest prediction, stalls at random
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall    <= 1'b0;
      stall_left   <= 0;
      results_seen <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        status_seen[out_item.status]++;
        if (awaited_results.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("unexpected result: value %0d status %0d occupancy %0d",
                     out_item.value_out, out_item.status, out_item.occupancy);
        end else begin
          want = awaited_results.pop_front();
          if (out_item.value_out !== want.value_out || out_item.status !== want.status ||
              out_item.occupancy !== want.occupancy) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display("result %0d: expected value %0d status %0d occupancy %0d, got %0d %0d %0d",
                       results_seen, want.value_out, want.status, want.occupancy,
                       out_item.value_out, out_item.status, out_item.occupancy);
          end
        end
      end
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_stall  <= 1'b1;
      end else if (!calm && $urandom_range(0, 2) == 0) begin
        stall_left <= pick_gap();
        out_stall  <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // cycle count, calm stretches and timeout
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count % 256 == 0) calm <= ($urandom_range(0, 3) == 0);
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d items taken, %0d results seen",
               cycle_count, items_taken, results_seen);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // stimulus, reset and end of run
  initial begin
    logic signed [31:0] pool[4];
    logic [1:0]         mode;
    logic signed [31:0] value;
    int unsigned        n_random;
    int unsigned        burst_len;
    int unsigned        lean;
    int unsigned        roll;
    int unsigned        put_lim;
    int unsigned        get_lim;
    bit                 drain_next;
    bit                 first_burst;

    // directed: empty queue, extremes, duplicates, no match, spare mode, full queue
    quiet = 1'b0;
    add_item(MODE_GET, $urandom, 1'b0);
    add_item(MODE_REMOVE, 32'sd5, 1'b0);
    add_item(MODE_PUT, 32'h8000_0000, 1'b0);
    add_item(MODE_PUT, 32'h7fff_ffff, 1'b0);
    add_item(MODE_PUT, -32'sd1, 1'b0);
    add_item(MODE_PUT, 32'sd0, 1'b0);
    add_item(MODE_PUT, -32'sd1, 1'b0);
    add_item(MODE_REMOVE, -32'sd1, 1'b0);
    add_item(MODE_REMOVE, 32'h1234_5678, 1'b0);
    add_item(MODE_SPARE, $urandom, 1'b0);
    add_item(MODE_GET, $urandom, 1'b0);
    for (int i = 0; i < 14; i++)
      add_item(MODE_PUT, (i % 3 == 0) ? 32'h7fff_ffff : $urandom, 1'b0);
    add_item(MODE_PUT, $urandom, 1'b0);
    // head value matches several entries further back too
    add_item(MODE_REMOVE, 32'h7fff_ffff, 1'b0);

    // random bursts leaning towards filling, draining or neither
    n_random    = 0;
    first_burst = 1'b1;
    while (n_random < RANDOM_ITEMS) begin
      burst_len  = $urandom_range(8, 60);
      lean       = $urandom_range(0, 2);
      quiet      = ($urandom_range(0, 4) == 0);
      drain_next = first_burst || ($urandom_range(0, 7) == 0);
      first_burst = 1'b0;
      for (int k = 0; k < 4; k++) pool[k] = pick_value();
      case (lean)
        0: begin
          put_lim = 80;
          get_lim = 88;
        end
        1: begin
          put_lim = 30;
          get_lim = 62;
        end
        default: begin
          put_lim = 48;
          get_lim = 72;
        end
      endcase
      for (int j = 0; j < burst_len; j++) begin
        roll = $urandom_range(0, 99);
        if (roll < put_lim) mode = MODE_PUT;
        else if (roll < get_lim) mode = MODE_GET;
        else if (roll < 97) mode = MODE_REMOVE;
        else mode = MODE_SPARE;
        value = ($urandom_range(0, 6) != 0) ? pool[$urandom_range(0, 3)] : $urandom;
        add_item(mode, value, drain_next && j == 0);
        if (mode != MODE_SPARE) n_random++;
      end
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_ops.size() != 0 || in_valid) @(posedge clk_i);
    while (items_taken != results_seen) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (awaited_results.size() != 0) begin
      $display("%0d expected results never arrived", awaited_results.size());
      mismatches += awaited_results.size();
    end
    $display("items taken: %0d put, %0d get, %0d remove, %0d unused mode",
             mode_taken[MODE_PUT], mode_taken[MODE_GET], mode_taken[MODE_REMOVE],
             mode_taken[MODE_SPARE]);
    $display("statuses seen: %0d ok, %0d empty, %0d full, %0d not found; %0d mismatches",
             status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_FULL],
             status_seen[ST_NOTFOUND], mismatches);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
